FILE: rtl/nsvl_pkg.sv
// Shared types, constants and helpers of the nearest-seed labeler.
`default_nettype none
package nsvl_pkg;

  localparam int unsigned MaxSeedsDefault    = 256;
  localparam int unsigned AddressBitsDefault = 30;

  localparam int unsigned PosW   = 18;
  localparam int unsigned DiffW  = 20;
  localparam int unsigned CoefW  = 21;
  localparam int unsigned RowW   = 63;
  localparam int unsigned ProdW  = DiffW + CoefW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned RndW   = SumW - 16;
  localparam int unsigned SqW    = 2 * RndW;
  localparam int unsigned ScoreW = 64;
  localparam int unsigned LabelW = 16;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [RowW-1:0] MetricXReset = 63'd2199023321088;
  localparam logic [RowW-1:0] MetricYReset = 63'd137438953472;
  localparam logic [RowW-1:0] MetricZReset = 63'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    RegMetricX   = 3'd0,
    RegMetricY   = 3'd1,
    RegMetricZ   = 3'd2,
    RegWrap      = 3'd3,
    RegWeighted  = 3'd4,
    RegSeedCount = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    ActLoad     = 1'b0,
    ActClassify = 1'b1
  } action_e;

  typedef struct packed {
    logic [RowW-1:0] row_x;
    logic [RowW-1:0] row_y;
    logic [RowW-1:0] row_z;
    logic [2:0]      wrap;
    logic            weighted;
  } metric_cfg_t;

  // Tag that rides along with a seed evaluation through the pipeline.
  typedef struct packed {
    logic first;
    logic last;
  } seed_tag_t;

  // Difference with the optional single fold by one unit.
  function automatic logic signed [DiffW-1:0] fold_diff(
      input logic signed [PosW-1:0] v, input logic signed [PosW-1:0] s,
      input logic wrap);
    logic signed [DiffW-1:0] d;
    d = DiffW'(v) - DiffW'(s);
    if (wrap) begin
      if (d > 20'sd32768) begin
        d = d - 20'sd65536;
      end
      if (d < -20'sd32768) begin
        d = d + 20'sd65536;
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nearest_seed_voronoi_labeler_unit.sv
// Top level: seed table, seed sweep, score pipeline and minimum tracker.
// A classify beat issues its n = max(1, min(seed_count, MAX_SEEDS)) seeds one after another
// to the single pipelined score unit; the input stays not ready until the result beat has
// been taken, so a voxel is done before the next input beat is accepted. A load beat writes
// the slot named in its data when it is below MAX_SEEDS, and the unit stays ready.
// Reset (rst_ni, async, active low) restores the configuration registers to defaults and clears
// control state; the seed table is not cleared and holds garbage until loaded.
`default_nettype none
module nearest_seed_voronoi_labeler_unit #(
  parameter int unsigned MAX_SEEDS    = nsvl_pkg::MaxSeedsDefault,
  parameter int unsigned ADDRESS_BITS = nsvl_pkg::AddressBitsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: slot[7:0], label[15:0], pos_x, pos_y, pos_z, weight
  // (18 each), voxel_address[29:0], zero pad to 128 bits.
  input  wire logic [127:0] s_axis_tdata,
  // tuser: action.
  input  wire logic         s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: out_address[29:0], nearest_label[15:0], zero pad.
  output logic [47:0]       m_axis_tdata,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [nsvl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [nsvl_pkg::CfgDataW-1:0] cfg_data_i
);
  import nsvl_pkg::*;

  localparam int unsigned IdxW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_SEEDS + 1);

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StIssue = 2'd1,
    StDrain = 2'd2,
    StOut   = 2'd3
  } state_e;

  // Configuration registers.
  metric_cfg_t cfg_q;
  logic [8:0]  seed_count_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x    <= MetricXReset;
      cfg_q.row_y    <= MetricYReset;
      cfg_q.row_z    <= MetricZReset;
      cfg_q.wrap     <= '0;
      cfg_q.weighted <= 1'b0;
      seed_count_q   <= 9'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegMetricX:   cfg_q.row_x    <= cfg_data_i[RowW-1:0];
        RegMetricY:   cfg_q.row_y    <= cfg_data_i[RowW-1:0];
        RegMetricZ:   cfg_q.row_z    <= cfg_data_i[RowW-1:0];
        RegWrap:      cfg_q.wrap     <= cfg_data_i[2:0];
        RegWeighted:  cfg_q.weighted <= cfg_data_i[0];
        RegSeedCount: seed_count_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [SlotW-1:0]       in_slot;
  logic [LabelW-1:0]      in_label;
  logic signed [PosW-1:0] in_x, in_y, in_z, in_w;
  logic [29:0]            in_addr;
  assign in_slot  = s_axis_tdata[7:0];
  assign in_label = s_axis_tdata[23:8];
  assign in_x     = s_axis_tdata[41:24];
  assign in_y     = s_axis_tdata[59:42];
  assign in_z     = s_axis_tdata[77:60];
  assign in_w     = s_axis_tdata[95:78];
  assign in_addr  = s_axis_tdata[125:96];

  // Seed table memory.
  localparam int unsigned EntW = LabelW + 4 * PosW;
  logic [EntW-1:0] mem [MAX_SEEDS];
  logic [EntW-1:0] rd_q;

  state_e state_q, state_d;
  logic [CntW-1:0] n_eff;
  logic [CntW-1:0] issue_q, issue_d;
  logic            rd_vld_q;
  seed_tag_t       rd_tag_q;
  logic signed [PosW-1:0] vx_q, vy_q, vz_q;
  logic [29:0]     addr_q;
  logic [LabelW-1:0] best_label_q;
  logic signed [ScoreW-1:0] best_q;
  logic            accept, load_we;

  // Score pipeline outputs.
  logic            dv;
  seed_tag_t       dtag;
  logic signed [ScoreW-1:0] dscore;
  logic [LabelW-1:0] lbl_pipe_q [5];

  always_comb begin
    if (seed_count_q == 9'd0) begin
      n_eff = CntW'(1);
    end else if (32'(seed_count_q) > MAX_SEEDS) begin
      n_eff = CntW'(MAX_SEEDS);
    end else begin
      n_eff = CntW'(seed_count_q);
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load_we = accept && (action_e'(s_axis_tuser) == ActLoad)
                   && (32'(in_slot) < MAX_SEEDS);

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[IdxW'(in_slot)] <= {in_label, in_w, in_z, in_y, in_x};
    end
    rd_q <= mem[issue_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    case (state_q)
      StIdle: begin
        issue_d = '0;
        if (accept && action_e'(s_axis_tuser) == ActClassify) begin
          state_d = StIssue;
        end
      end
      StIssue: begin
        issue_d = issue_q + CntW'(1);
        if (issue_q + CntW'(1) == n_eff) begin
          state_d = StDrain;
        end
      end
      StDrain: if (dv && dtag.last) state_d = StOut;
      StOut: if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  nsvl_dist u_dist (
    .clk_i, .rst_ni,
    .valid_i (rd_vld_q),
    .tag_i   (rd_tag_q),
    .vox_x_i (vx_q), .vox_y_i (vy_q), .vox_z_i (vz_q),
    .seed_x_i(rd_q[PosW-1:0]),
    .seed_y_i(rd_q[2*PosW-1:PosW]),
    .seed_z_i(rd_q[3*PosW-1:2*PosW]),
    .weight_i(rd_q[4*PosW-1:3*PosW]),
    .cfg_i   (cfg_q),
    .valid_o (dv), .tag_o (dtag), .score_o (dscore)
  );

  // Labels ride alongside the score pipeline.
  always_ff @(posedge clk_i) begin
    lbl_pipe_q[0] <= rd_q[EntW-1:4*PosW];
    for (int i = 1; i < 5; i++) lbl_pipe_q[i] <= lbl_pipe_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      rd_vld_q <= (state_q == StIssue);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q.first <= (issue_q == '0);
    rd_tag_q.last  <= (issue_q + CntW'(1) == n_eff);
    if (accept) begin
      vx_q <= in_x; vy_q <= in_y; vz_q <= in_z;
      addr_q <= in_addr & 30'((64'd1 << ADDRESS_BITS) - 64'd1);
    end
    if (dv && (dtag.first || dscore < best_q)) begin
      best_q       <= dscore;
      best_label_q <= lbl_pipe_q[4];
    end
  end

  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata  = {2'b00, best_label_q, addr_q};

endmodule
`default_nettype wire

FILE: rtl/nsvl_dist.sv
// Pipelined score unit: one seed per cycle, five register stages.
`default_nettype none
module nsvl_dist (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire nsvl_pkg::seed_tag_t           tag_i,
  input  wire logic signed [17:0]            vox_x_i,
  input  wire logic signed [17:0]            vox_y_i,
  input  wire logic signed [17:0]            vox_z_i,
  input  wire logic signed [17:0]            seed_x_i,
  input  wire logic signed [17:0]            seed_y_i,
  input  wire logic signed [17:0]            seed_z_i,
  input  wire logic signed [17:0]            weight_i,
  input  wire nsvl_pkg::metric_cfg_t         cfg_i,
  output logic                               valid_o,
  output nsvl_pkg::seed_tag_t                tag_o,
  output logic signed [nsvl_pkg::ScoreW-1:0] score_o
);
  import nsvl_pkg::*;

  localparam int unsigned Stages = 5;

  logic [Stages-1:0] vld_q;
  seed_tag_t         tag_q  [Stages];

  // Stage 1: folded differences and weight.
  logic signed [DiffW-1:0] d_q [3];
  logic signed [PosW-1:0]  w1_q;
  // Stage 2: nine products.
  logic signed [ProdW-1:0] p_q [3][3];
  logic signed [PosW-1:0]  w2_q;
  // Stage 3: rounded row sums.
  logic signed [RndW-1:0]  r_q [3];
  logic signed [2*PosW-1:0] w3_q;
  // Stage 4: squares.
  logic signed [SqW-1:0]   sq_q [3];
  logic signed [2*PosW-1:0] w4_q;
  // Stage 5: score.
  logic signed [ScoreW-1:0] score_q;

  logic signed [CoefW-1:0] coef [3][3];
  logic [RowW-1:0] rows [3];

  always_comb begin
    rows[0] = cfg_i.row_x;
    rows[1] = cfg_i.row_y;
    rows[2] = cfg_i.row_z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[r][c] = rows[r][21*c +: CoefW];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [SumW-1:0] s;
    logic signed [SumW-1:0] sr;
    tag_q[0]  <= tag_i;
    for (int i = 1; i < Stages; i++) begin
      tag_q[i]  <= tag_q[i-1];
    end
    d_q[0] <= fold_diff(vox_x_i, seed_x_i, cfg_i.wrap[0]);
    d_q[1] <= fold_diff(vox_y_i, seed_y_i, cfg_i.wrap[1]);
    d_q[2] <= fold_diff(vox_z_i, seed_z_i, cfg_i.wrap[2]);
    w1_q   <= weight_i;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        p_q[r][c] <= ProdW'(coef[r][c]) * ProdW'(d_q[c]);
      end
    end
    w2_q <= w1_q;
    for (int r = 0; r < 3; r++) begin
      s = SumW'(p_q[r][0]) + SumW'(p_q[r][1]) + SumW'(p_q[r][2]);
      sr = s + SumW'(32768);
      r_q[r] <= sr[SumW-1:16];
    end
    w3_q <= (2*PosW)'(w2_q) * (2*PosW)'(w2_q);
    for (int r = 0; r < 3; r++) begin
      sq_q[r] <= SqW'(r_q[r]) * SqW'(r_q[r]);
    end
    w4_q <= w3_q;
    score_q <= ScoreW'(sq_q[0]) + ScoreW'(sq_q[1]) + ScoreW'(sq_q[2])
             - (cfg_i.weighted ? ScoreW'(w4_q) : ScoreW'(0));
  end

  assign valid_o = vld_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];
  assign score_o = score_q;

endmodule
`default_nettype wire

FILE: bench/label_checker.sv
// Checker for the nearest-seed labeler: tracks its seed table, predicts and compares results.
module label_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [nsvl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [nsvl_pkg::CfgDataW-1:0] cfg_data_i,
  output int           mismatch_o,
  output int           pending_o,
  output int           results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import nsvl_pkg::*;

  typedef struct {
    logic [29:0] address;
    logic [15:0] label;
  } voxel_result_t;

  voxel_result_t label_q[$];

  logic [RowW-1:0] metric_rows [3];
  logic [2:0]      wrap_axes;
  logic            use_weights;
  logic [8:0]      search_count;

  logic [15:0] table_label  [256];
  longint      table_pos    [256][3];
  longint      table_weight [256];

  // Nearest-seed search over the active slots, a power diagram when weighted; the lowest slot keeps a tie.
  function automatic logic [15:0] nearest_label(longint vox[3]);
    longint best, total, d[3], s, q, cf;
    int unsigned n, winner;
    n = (search_count == 0) ? 1 : (search_count > 256) ? 256 : search_count;
    best = 0;
    winner = 0;
    for (int unsigned k = 0; k < n; k++) begin
      total = 0;
      for (int a = 0; a < 3; a++) begin
        d[a] = vox[a] - table_pos[k][a];
        if (wrap_axes[a]) begin
          if (d[a] > 32768) d[a] -= 65536;
          if (d[a] < -32768) d[a] += 65536;
        end
      end
      for (int r = 0; r < 3; r++) begin
        s = 0;
        for (int c = 0; c < 3; c++) begin
          cf = $signed(metric_rows[r][21*c +: 21]);
          s += cf * d[c];
        end
        q = (s + 32768) >>> 16;
        total += q * q;
      end
      if (use_weights) total -= table_weight[k] * table_weight[k];
      if (k == 0 || total < best) begin
        best = total;
        winner = k;
      end
    end
    return table_label[winner];
  endfunction

  always @(posedge clk_i) begin
    voxel_result_t got, want;
    longint vox[3];
    logic [7:0] slot;
    if (!rst_ni) begin
      metric_rows[0] = MetricXReset;
      metric_rows[1] = MetricYReset;
      metric_rows[2] = MetricZReset;
      wrap_axes      = '0;
      use_weights    = 1'b0;
      search_count   = 9'd1;
      mismatch_o     = 0;
      results_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          RegMetricX:   metric_rows[0] = cfg_data_i[RowW-1:0];
          RegMetricY:   metric_rows[1] = cfg_data_i[RowW-1:0];
          RegMetricZ:   metric_rows[2] = cfg_data_i[RowW-1:0];
          RegWrap:      wrap_axes      = cfg_data_i[2:0];
          RegWeighted:  use_weights    = cfg_data_i[0];
          RegSeedCount: search_count   = cfg_data_i[8:0];
          default: ;
        endcase
      end
      // Results leave before the beat accepted at the same edge can be counted.
      if (m_axis_tvalid && m_axis_tready) begin
        got.address = m_axis_tdata[29:0];
        got.label   = m_axis_tdata[45:30];
        results_o++;
        if (label_q.size() == 0) begin
          mismatch_o++;
          if (mismatch_o <= 10)
            $display("%0t: result beat with nothing expected: addr %h label %h",
                     $realtime, got.address, got.label);
        end else begin
          want = label_q.pop_front();
          if (got.address !== want.address || got.label !== want.label) begin
            mismatch_o++;
            if (mismatch_o <= 10)
              $display("%0t: mismatch: expected addr %h label %h, got addr %h label %h",
                       $realtime, want.address, want.label, got.address, got.label);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        vox[0] = $signed(s_axis_tdata[41:24]);
        vox[1] = $signed(s_axis_tdata[59:42]);
        vox[2] = $signed(s_axis_tdata[77:60]);
        if (action_e'(s_axis_tuser) == ActLoad) begin
          slot = s_axis_tdata[7:0];
          table_label[slot]  = s_axis_tdata[23:8];
          for (int a = 0; a < 3; a++) table_pos[slot][a] = vox[a];
          table_weight[slot] = $signed(s_axis_tdata[95:78]);
        end else begin
          want.address = s_axis_tdata[125:96];
          want.label   = nearest_label(vox);
          label_q.push_back(want);
        end
      end
    end
    pending_o = label_q.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the labeler bench: clock, reset, stimulus phases and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nsvl_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [127:0]       s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int mismatches, pending, results;
  int unsigned beats_sent, phases_run;
  bit calm;
  bit written [256];
  int unsigned active_seeds;

  localparam logic [62:0] CoefOne = 63'd65536;

  always #2 clk_i = ~clk_i;

  nearest_seed_voronoi_labeler_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  label_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .mismatch_o(mismatches), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  task automatic send_beat(action_e act, logic [7:0] slot, logic [15:0] label,
                           logic [17:0] px, logic [17:0] py, logic [17:0] pz,
                           logic [17:0] w, logic [29:0] address);
    if (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, address, w, pz, py, px, label, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
    if (act == ActLoad) written[slot] = 1'b1;
    calm = (beats_sent >= 700 && beats_sent < 1000);
  endtask

  function automatic logic [17:0] pick_pos();
    logic [17:0] v;
    case ($urandom_range(3))
      0: v = 18'(($urandom_range(7) - 4) * 32768);
      1: case ($urandom_range(4))
           0: v = 18'h20000;
           1: v = 18'h1FFFF;
           2: v = 18'd32768;
           3: v = 18'h38000;
           default: v = '0;
         endcase
      default: v = 18'($urandom);
    endcase
    return v;
  endfunction

  task automatic random_beat();
    if ($urandom_range(99) < 30)
      send_beat(ActLoad,
                ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(active_seeds - 1)),
                16'($urandom), pick_pos(), pick_pos(), pick_pos(), pick_pos(), 30'($urandom));
    else
      send_beat(ActClassify, 8'($urandom), 16'($urandom), pick_pos(), pick_pos(), pick_pos(),
                18'($urandom), 30'($urandom));
  endtask

  // Drains the block; a trailing load may still be in flight, so wait out a full sweep too.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic cfg_beat(cfg_reg_e idx, logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_phase(logic [62:0] rx, logic [62:0] ry, logic [62:0] rz,
                           logic [2:0] wrap, logic weighted, logic [8:0] count);
    drain();
    cfg_beat(RegMetricX, 64'(rx));
    cfg_beat(RegMetricY, 64'(ry));
    cfg_beat(RegMetricZ, 64'(rz));
    cfg_beat(RegWrap, 64'(wrap));
    cfg_beat(RegWeighted, 64'(weighted));
    cfg_beat(RegSeedCount, 64'(count));
    cfg_valid_i <= 1'b0;
    phases_run++;
    active_seeds = (count == 0) ? 1 : (count > 256) ? 256 : count;
    // Every searched slot must hold a seed before the first voxel.
    for (int s = 0; s < active_seeds; s++)
      if (!written[s])
        send_beat(ActLoad, 8'(s), 16'($urandom), pick_pos(), pick_pos(), pick_pos(),
                  18'($urandom), '0);
  endtask

  function automatic logic [62:0] random_row();
    return 63'({$urandom, $urandom});
  endfunction

  initial begin
    logic [62:0] coef_max, coef_min;
    coef_max = {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF};
    coef_min = {21'h100000, 21'h100000, 21'h100000};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one seed, one voxel.
    active_seeds = 1;
    send_beat(ActLoad, 8'd0, 16'h1234, 18'd100, 18'h3FF00, 18'd5, 18'd7, '0);
    send_beat(ActClassify, '0, '0, 18'd200, 18'd300, 18'h20000, '0, 30'h2AAAAAAA);

    // Identity metric, every axis repeating; ties, half-unit folds and far differences.
    set_phase(CoefOne, CoefOne << 21, CoefOne << 42, 3'b111, 1'b0, 9'd4);
    send_beat(ActLoad, 8'd0, 16'h0000, '0, '0, '0, '0, '0);
    send_beat(ActLoad, 8'd1, 16'hFFFF, '0, '0, '0, 18'h1FFFF, '0);
    send_beat(ActLoad, 8'd2, 16'h00A2, 18'd65536, 18'd65536, 18'd65536, 18'h1FFFF, '0);
    send_beat(ActLoad, 8'd3, 16'h00A3, 18'h20000, 18'h20000, 18'h20000, 18'h20000, '0);
    send_beat(ActLoad, 8'd255, 16'hBEEF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h20000,
              30'h3FFFFFFF);
    send_beat(ActClassify, '0, '0, '0, '0, '0, '0, 30'h0);
    send_beat(ActClassify, '0, '0, 18'd32768, '0, '0, '0, 30'h3FFFFFFF);
    send_beat(ActClassify, '0, '0, 18'h38000, 18'd32768, 18'h38000, '0, 30'h1);
    send_beat(ActClassify, '0, '0, 18'd98304, 18'h28000, '0, '0, 30'h2);
    send_beat(ActClassify, '0, '0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, '0, 30'h3);
    send_beat(ActClassify, '0, '0, 18'h20000, 18'h20000, 18'h20000, '0, 30'h4);
    send_beat(ActClassify, '0, '0, 18'd32769, 18'h37FFF, 18'd65536, '0, 30'h5);

    // Weighted with seed count zero, then the same seeds under a four-seed search.
    set_phase(CoefOne, CoefOne << 21, CoefOne << 42, 3'b010, 1'b1, 9'd0);
    repeat (6) random_beat();
    set_phase(CoefOne, CoefOne << 21, CoefOne << 42, 3'b000, 1'b1, 9'd4);
    send_beat(ActClassify, '0, '0, '0, '0, '0, '0, 30'h6);
    send_beat(ActClassify, '0, '0, 18'h20000, 18'h20000, 18'h20000, '0, 30'h7);

    // Extreme and zero coefficients with the largest searches.
    set_phase(coef_max, coef_max, coef_max, 3'b000, 1'b1, 9'd511);
    repeat (25) random_beat();
    set_phase(coef_min, coef_min, coef_min, 3'b101, 1'b0, 9'd257);
    repeat (25) random_beat();
    set_phase('0, '0, '0, 3'b011, 1'b0, 9'd256);
    repeat (8) random_beat();

    for (int p = 0; p < 8; p++) begin
      set_phase(random_row(), random_row(), random_row(), 3'($urandom), 1'($urandom),
                ($urandom_range(3) == 0) ? 9'($urandom_range(17, 64))
                                         : 9'($urandom_range(1, 16)));
      repeat (200) random_beat();
    end

    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 100000 && pending != 0; w++) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("Sent %0d input beats over %0d settings; %0d voxel results checked.",
             beats_sent, phases_run, results);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/nsvl_pkg.sv
rtl/nsvl_dist.sv
rtl/nearest_seed_voronoi_labeler_unit.sv
bench/label_checker.sv
bench/testbench.sv
